>>> rtl/assert_macros.svh
// Assertion macros shared by the RTL; empty when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPL(lbl, ante, cons)
`define ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

>>> rtl/lsc_pkg.sv
// Types and constants for the 3x3 Cramer's rule solver
`default_nettype none
package lsc_pkg;
    localparam int IN_W = 16;
    localparam int PROD_W = 2 * IN_W;
    localparam int COF_W = PROD_W + 1;
    localparam int TERM_W = IN_W + COF_W;
    localparam int DET_W = TERM_W + 1;
    localparam int MAG_W = DET_W - 1;
    localparam int THR_W = 49;
    localparam int QW = 32;
    localparam int OUT_FRAC_BITS_DEF = 16;
    localparam int DET_LAT = 4;
    localparam int DIV_LAT = QW + 1;
    localparam int PIPE_LAT = DET_LAT + DIV_LAT;

    typedef struct packed {
        logic signed [IN_W-1:0] m11;
        logic signed [IN_W-1:0] m12;
        logic signed [IN_W-1:0] m13;
        logic signed [IN_W-1:0] m21;
        logic signed [IN_W-1:0] m22;
        logic signed [IN_W-1:0] m23;
        logic signed [IN_W-1:0] m31;
        logic signed [IN_W-1:0] m32;
        logic signed [IN_W-1:0] m33;
        logic signed [IN_W-1:0] rhs1;
        logic signed [IN_W-1:0] rhs2;
        logic signed [IN_W-1:0] rhs3;
    } sys_t;

    typedef enum logic [1:0] {
        ST_SUCCESS  = 2'd0,
        ST_ILL      = 2'd1,
        ST_SINGULAR = 2'd2
    } status_t;
endpackage
`default_nettype wire

>>> rtl/lsc_det.sv
// Four-stage exact determinant and replacement determinant pipeline
`default_nettype none
module lsc_det (
    input  wire logic                             clk,
    input  wire logic                             en,
    input  wire lsc_pkg::sys_t                    sys_in,
    output logic signed [lsc_pkg::DET_W-1:0]      det,
    output logic signed [lsc_pkg::DET_W-1:0]      d1,
    output logic signed [lsc_pkg::DET_W-1:0]      d2,
    output logic signed [lsc_pkg::DET_W-1:0]      d3
);
    import lsc_pkg::*;

    // stage 1: 2x2 products
    logic signed [PROD_W-1:0] p1_reg, p2_reg, p3_reg, p4_reg, p5_reg, p6_reg, p7_reg;
    logic signed [PROD_W-1:0] p8_reg, p9_reg, p10_reg, p11_reg, p12_reg, p13_reg, p14_reg;
    logic signed [IN_W-1:0]   a11_s1_reg, a12_s1_reg, a13_s1_reg, b1_s1_reg;
    // stage 2: cofactors
    logic signed [COF_W-1:0]  c1_reg, c2_reg, c3_reg, e1_reg, e2_reg, e3_reg, f_reg;
    logic signed [IN_W-1:0]   a11_s2_reg, a12_s2_reg, a13_s2_reg, b1_s2_reg;
    // stage 3: terms
    logic signed [TERM_W-1:0] t_reg [12];
    // stage 4: sums
    logic signed [DET_W-1:0]  det_reg, d1_reg, d2_reg, d3_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1_reg  <= $signed(sys_in.m22) * $signed(sys_in.m33);
            p2_reg  <= $signed(sys_in.m23) * $signed(sys_in.m32);
            p3_reg  <= $signed(sys_in.m21) * $signed(sys_in.m33);
            p4_reg  <= $signed(sys_in.m23) * $signed(sys_in.m31);
            p5_reg  <= $signed(sys_in.m21) * $signed(sys_in.m32);
            p6_reg  <= $signed(sys_in.m22) * $signed(sys_in.m31);
            p7_reg  <= $signed(sys_in.rhs2) * $signed(sys_in.m33);
            p8_reg  <= $signed(sys_in.rhs3) * $signed(sys_in.m23);
            p9_reg  <= $signed(sys_in.rhs2) * $signed(sys_in.m32);
            p10_reg <= $signed(sys_in.rhs3) * $signed(sys_in.m22);
            p11_reg <= $signed(sys_in.m21) * $signed(sys_in.rhs3);
            p12_reg <= $signed(sys_in.m31) * $signed(sys_in.rhs2);
            p13_reg <= $signed(sys_in.m22) * $signed(sys_in.rhs3);
            p14_reg <= $signed(sys_in.m32) * $signed(sys_in.rhs2);
            a11_s1_reg <= sys_in.m11;
            a12_s1_reg <= sys_in.m12;
            a13_s1_reg <= sys_in.m13;
            b1_s1_reg  <= sys_in.rhs1;

            c1_reg <= COF_W'(p1_reg) - COF_W'(p2_reg);
            c2_reg <= COF_W'(p3_reg) - COF_W'(p4_reg);
            c3_reg <= COF_W'(p5_reg) - COF_W'(p6_reg);
            e1_reg <= COF_W'(p7_reg) - COF_W'(p8_reg);
            e2_reg <= COF_W'(p9_reg) - COF_W'(p10_reg);
            e3_reg <= COF_W'(p11_reg) - COF_W'(p12_reg);
            f_reg  <= COF_W'(p13_reg) - COF_W'(p14_reg);
            a11_s2_reg <= a11_s1_reg;
            a12_s2_reg <= a12_s1_reg;
            a13_s2_reg <= a13_s1_reg;
            b1_s2_reg  <= b1_s1_reg;

            t_reg[0]  <= a11_s2_reg * c1_reg;
            t_reg[1]  <= a12_s2_reg * c2_reg;
            t_reg[2]  <= a13_s2_reg * c3_reg;
            t_reg[3]  <= b1_s2_reg * c1_reg;
            t_reg[4]  <= a12_s2_reg * e1_reg;
            t_reg[5]  <= a13_s2_reg * e2_reg;
            t_reg[6]  <= a11_s2_reg * e1_reg;
            t_reg[7]  <= b1_s2_reg * c2_reg;
            t_reg[8]  <= a13_s2_reg * e3_reg;
            t_reg[9]  <= a11_s2_reg * f_reg;
            t_reg[10] <= a12_s2_reg * e3_reg;
            t_reg[11] <= b1_s2_reg * c3_reg;

            det_reg <= DET_W'(t_reg[0]) - DET_W'(t_reg[1]) + DET_W'(t_reg[2]);
            d1_reg  <= DET_W'(t_reg[3]) - DET_W'(t_reg[4]) + DET_W'(t_reg[5]);
            d2_reg  <= DET_W'(t_reg[6]) - DET_W'(t_reg[7]) + DET_W'(t_reg[8]);
            d3_reg  <= DET_W'(t_reg[9]) - DET_W'(t_reg[10]) + DET_W'(t_reg[11]);
        end
    end

    assign det = det_reg;
    assign d1  = d1_reg;
    assign d2  = d2_reg;
    assign d3  = d3_reg;
endmodule
`default_nettype wire

>>> rtl/lsc_div.sv
// Pipelined restoring divider, one quotient bit per stage, magnitude quotient
`default_nettype none
module lsc_div #(
    parameter int OUT_FRAC_BITS = lsc_pkg::OUT_FRAC_BITS_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             en,
    input  wire logic signed [lsc_pkg::DET_W-1:0] num,
    input  wire logic signed [lsc_pkg::DET_W-1:0] den,
    output logic [lsc_pkg::QW-1:0]                quo,
    output logic                                  neg,
    output logic                                  ovf_pre
);
    import lsc_pkg::*;

    localparam int SH = QW - OUT_FRAC_BITS;

    logic [MAG_W-1:0] an, ad, rem0;
    logic [MAG_W-1:0] rem_reg [0:QW-1];
    logic [MAG_W-1:0] ad_reg  [0:QW-1];
    logic [QW-1:0]    nlo_reg [0:QW-1];
    logic [QW-1:0]    quo_reg [0:QW];
    logic             neg_reg [0:QW];
    logic             ovp_reg [0:QW];
    logic [MAG_W:0]   trial [1:QW];
    logic [MAG_W:0]   diff  [1:QW];
    logic             take  [1:QW];

    always_comb
    begin
        an   = MAG_W'(num[DET_W-1] ? -num : num);
        ad   = MAG_W'(den[DET_W-1] ? -den : den);
        rem0 = MAG_W'(an >> SH);
        for (int k = 1; k <= QW; k++)
        begin
            trial[k] = {rem_reg[k-1], nlo_reg[k-1][QW-1]};
            diff[k]  = trial[k] - {1'b0, ad_reg[k-1]};
            take[k]  = trial[k] >= {1'b0, ad_reg[k-1]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= rem0;
            ad_reg[0]  <= ad;
            nlo_reg[0] <= QW'(an << OUT_FRAC_BITS);
            quo_reg[0] <= '0;
            neg_reg[0] <= num[DET_W-1] ^ den[DET_W-1];
            ovp_reg[0] <= rem0 >= ad;
            for (int k = 1; k < QW; k++)
            begin
                rem_reg[k] <= take[k] ? MAG_W'(diff[k]) : MAG_W'(trial[k]);
                ad_reg[k]  <= ad_reg[k-1];
                nlo_reg[k] <= {nlo_reg[k-1][QW-2:0], 1'b0};
            end
            for (int k = 1; k <= QW; k++)
            begin
                quo_reg[k] <= {quo_reg[k-1][QW-2:0], take[k]};
                neg_reg[k] <= neg_reg[k-1];
                ovp_reg[k] <= ovp_reg[k-1];
            end
        end
    end

    assign quo     = quo_reg[QW];
    assign neg     = neg_reg[QW];
    assign ovf_pre = ovp_reg[QW];
endmodule
`default_nettype wire

>>> rtl/linear_solve_3x3_cramer.sv
// Top level of the pipelined 3x3 Cramer's rule solver
// Throughput: one item per cycle unless stalled; every stage, quotient-bit ones too, is pipelined.
// A stalled output holds the whole pipeline; no item is lost or repeated.
// Reset clears all valid bits and sets the ill threshold thr_reg to 1; no clearing pass.
`default_nettype none
`include "assert_macros.svh"
module linear_solve_3x3_cramer #(
    parameter int OUT_FRAC_BITS = lsc_pkg::OUT_FRAC_BITS_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [lsc_pkg::THR_W-1:0]         cfg_wdata,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic signed [lsc_pkg::IN_W-1:0]   m11,
    input  wire logic signed [lsc_pkg::IN_W-1:0]   m12,
    input  wire logic signed [lsc_pkg::IN_W-1:0]   m13,
    input  wire logic signed [lsc_pkg::IN_W-1:0]   m21,
    input  wire logic signed [lsc_pkg::IN_W-1:0]   m22,
    input  wire logic signed [lsc_pkg::IN_W-1:0]   m23,
    input  wire logic signed [lsc_pkg::IN_W-1:0]   m31,
    input  wire logic signed [lsc_pkg::IN_W-1:0]   m32,
    input  wire logic signed [lsc_pkg::IN_W-1:0]   m33,
    input  wire logic signed [lsc_pkg::IN_W-1:0]   rhs1,
    input  wire logic signed [lsc_pkg::IN_W-1:0]   rhs2,
    input  wire logic signed [lsc_pkg::IN_W-1:0]   rhs3,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic signed [lsc_pkg::QW-1:0]          sol1,
    output logic signed [lsc_pkg::QW-1:0]          sol2,
    output logic signed [lsc_pkg::QW-1:0]          sol3,
    output logic [1:0]                             status,
    output logic                                   overflow
);
    import lsc_pkg::*;

    localparam logic [QW-1:0] SAT_POS = {1'b0, {(QW-1){1'b1}}};
    localparam logic [QW-1:0] SAT_NEG = {1'b1, {(QW-1){1'b0}}};

    logic                    en;
    sys_t                    sys_in;
    logic signed [DET_W-1:0] det, dn [3];
    logic [MAG_W-1:0]        det_mag;
    logic [QW-1:0]           quo [3];
    logic                    neg [3], ovp [3];
    logic [QW-1:0]           sol_next [3];
    logic                    ovf_lane [3];
    logic                    ovf_next;

    logic                    v_reg    [0:PIPE_LAT-1];
    logic                    sing_reg [0:DIV_LAT-1];
    logic                    ill_reg  [0:DIV_LAT-1];
    logic [THR_W-1:0]        thr_reg;
    logic                    out_valid_reg;
    logic [QW-1:0]           sol1_reg, sol2_reg, sol3_reg;
    status_t                 status_reg;
    logic                    overflow_reg;

    assign en       = !(out_valid_reg && out_stall);
    assign in_stall = !en;

    assign sys_in = '{m11: m11, m12: m12, m13: m13, m21: m21, m22: m22, m23: m23,
                      m31: m31, m32: m32, m33: m33, rhs1: rhs1, rhs2: rhs2, rhs3: rhs3};

    lsc_det u_det (
        .clk    (clk),
        .en     (en),
        .sys_in (sys_in),
        .det    (det),
        .d1     (dn[0]),
        .d2     (dn[1]),
        .d3     (dn[2])
    );

    for (genvar i = 0; i < 3; i++)
    begin : g_div
        lsc_div #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_div (
            .clk     (clk),
            .en      (en),
            .num     (dn[i]),
            .den     (det),
            .quo     (quo[i]),
            .neg     (neg[i]),
            .ovf_pre (ovp[i])
        );
    end

    assign det_mag = MAG_W'(det[DET_W-1] ? -det : det);

    // saturation and sign
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (ovp[i])
                ovf_lane[i] = 1'b1;
            else if (neg[i])
                ovf_lane[i] = quo[i][QW-1] && (quo[i][QW-2:0] != '0);
            else
                ovf_lane[i] = quo[i][QW-1];
            if (ovf_lane[i])
                sol_next[i] = neg[i] ? SAT_NEG : SAT_POS;
            else
                sol_next[i] = neg[i] ? QW'(-quo[i]) : quo[i];
        end
        ovf_next = ovf_lane[0] || ovf_lane[1] || ovf_lane[2];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= THR_W'(1);
        end
        else if (cfg_we)
        begin
            thr_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < PIPE_LAT; k++)
                v_reg[k] <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            v_reg[0] <= in_valid;
            for (int k = 1; k < PIPE_LAT; k++)
                v_reg[k] <= v_reg[k-1];
            out_valid_reg <= v_reg[PIPE_LAT-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sing_reg[0] <= det == '0;
            ill_reg[0]  <= THR_W'(det_mag) < thr_reg;
            for (int k = 1; k < DIV_LAT; k++)
            begin
                sing_reg[k] <= sing_reg[k-1];
                ill_reg[k]  <= ill_reg[k-1];
            end
            if (sing_reg[DIV_LAT-1])
            begin
                sol1_reg     <= '0;
                sol2_reg     <= '0;
                sol3_reg     <= '0;
                status_reg   <= ST_SINGULAR;
                overflow_reg <= 1'b0;
            end
            else
            begin
                sol1_reg     <= sol_next[0];
                sol2_reg     <= sol_next[1];
                sol3_reg     <= sol_next[2];
                status_reg   <= ill_reg[DIV_LAT-1] ? ST_ILL : ST_SUCCESS;
                overflow_reg <= ovf_next;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign sol1      = sol1_reg;
    assign sol2      = sol2_reg;
    assign sol3      = sol3_reg;
    assign status    = status_reg;
    assign overflow  = overflow_reg;

    `ASSERT_NEXT(a_accept_enters, in_valid && !in_stall, v_reg[0])
    `ASSERT_IMPL(a_singular_zero, out_valid_reg && status_reg == ST_SINGULAR,
        sol1_reg == '0 && sol2_reg == '0 && sol3_reg == '0 && !overflow_reg)
    `ASSERT_IMPL(a_ovf_sat, out_valid_reg && overflow_reg,
        sol1_reg == SAT_POS || sol1_reg == SAT_NEG || sol2_reg == SAT_POS ||
        sol2_reg == SAT_NEG || sol3_reg == SAT_POS || sol3_reg == SAT_NEG)
endmodule
`default_nettype wire

>>> tb/sv/tb.sv
// Testbench for the 3x3 Cramer's rule solver: random and directed systems, scoreboard check
`timescale 1ns / 100ps
`default_nettype none
module tb;
    import lsc_pkg::*;

    typedef struct {
        logic signed [31:0] s1, s2, s3;
        status_t            st;
        logic               ovf;
    } solution_t;

    class solution_board;
        solution_t pending[$];
        logic [THR_W-1:0] thr;
        int errors;

        function new();
            thr = 1;
            errors = 0;
        endfunction

        function logic [31:0] quot(longint num, longint den, ref bit ovf);
            bit neg;
            logic [63:0] an, ad, q, r, lim;
            neg = (num < 0) != (den < 0);
            an = num < 0 ? -num : num;
            ad = den < 0 ? -den : den;
            q = an / ad;
            r = an % ad;
            lim = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
            if (q >= 64'h1_0000_0000)
                q = lim + 1;
            else
                for (int i = 0; i < 16; i++)
                begin
                    r = r << 1;
                    q = q << 1;
                    if (r >= ad)
                    begin
                        r = r - ad;
                        q[0] = 1'b1;
                    end
                end
            if (q > lim)
            begin
                ovf = 1;
                q = lim;
            end
            return neg ? 32'(-q) : q[31:0];
        endfunction

        function void note_system(sys_t s);
            longint a11, a12, a13, a21, a22, a23, a31, a32, a33, b1, b2, b3;
            longint c1, c2, c3, e1, e2, e3, det, d1, d2, d3, mag;
            bit ovf;
            solution_t x;
            a11 = s.m11; a12 = s.m12; a13 = s.m13;
            a21 = s.m21; a22 = s.m22; a23 = s.m23;
            a31 = s.m31; a32 = s.m32; a33 = s.m33;
            b1 = s.rhs1; b2 = s.rhs2; b3 = s.rhs3;
            c1 = a22 * a33 - a23 * a32;
            c2 = a21 * a33 - a23 * a31;
            c3 = a21 * a32 - a22 * a31;
            det = a11 * c1 - a12 * c2 + a13 * c3;
            e1 = b2 * a33 - b3 * a23;
            e2 = b2 * a32 - b3 * a22;
            e3 = a21 * b3 - a31 * b2;
            d1 = b1 * c1 - a12 * e1 + a13 * e2;
            d2 = a11 * e1 - b1 * c2 + a13 * e3;
            d3 = a11 * (a22 * b3 - a32 * b2) - a12 * e3 + b1 * c3;
            ovf = 0;
            if (det == 0)
            begin
                x.s1 = 0; x.s2 = 0; x.s3 = 0; x.st = ST_SINGULAR; x.ovf = 0;
            end
            else
            begin
                x.s1 = quot(d1, det, ovf);
                x.s2 = quot(d2, det, ovf);
                x.s3 = quot(d3, det, ovf);
                mag = det < 0 ? -det : det;
                x.st = (64'(mag) < 64'(thr)) ? ST_ILL : ST_SUCCESS;
                x.ovf = ovf;
            end
            pending.push_back(x);
        endfunction

        function void check_solution(logic [31:0] s1, s2, s3, logic [1:0] st, logic ovf);
            solution_t x;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected result sol1=%h", $time, s1);
                errors++;
                return;
            end
            x = pending.pop_front();
            if (s1 !== x.s1)
            begin
                $display("%0t: sol1 exp %h got %h", $time, x.s1, s1); errors++;
            end
            if (s2 !== x.s2)
            begin
                $display("%0t: sol2 exp %h got %h", $time, x.s2, s2); errors++;
            end
            if (s3 !== x.s3)
            begin
                $display("%0t: sol3 exp %h got %h", $time, x.s3, s3); errors++;
            end
            if (st !== x.st)
            begin
                $display("%0t: status exp %0d got %0d", $time, x.st, st); errors++;
            end
            if (ovf !== x.ovf)
            begin
                $display("%0t: overflow exp %b got %b", $time, x.ovf, ovf); errors++;
            end
        endfunction
    endclass

    logic clk = 0, rst_n = 0, cfg_we = 0, in_valid = 0, out_stall = 0;
    logic [THR_W-1:0] cfg_wdata = '0;
    sys_t sys_in = '0;
    logic in_stall, out_valid, overflow;
    logic signed [31:0] sol1, sol2, sol3;
    logic [1:0] status;
    bit calm = 0;
    longint cycles = 0;
    solution_board board = new();

    linear_solve_3x3_cramer dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .in_valid(in_valid), .in_stall(in_stall),
        .m11(sys_in.m11), .m12(sys_in.m12), .m13(sys_in.m13),
        .m21(sys_in.m21), .m22(sys_in.m22), .m23(sys_in.m23),
        .m31(sys_in.m31), .m32(sys_in.m32), .m33(sys_in.m33),
        .rhs1(sys_in.rhs1), .rhs2(sys_in.rhs2), .rhs3(sys_in.rhs3),
        .out_valid(out_valid), .out_stall(out_stall),
        .sol1(sol1), .sol2(sol2), .sol3(sol3), .status(status), .overflow(overflow)
    );

    always
    begin
        #4 clk = 1;
        #4 clk = 0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > 400000)
        begin
            $display("simulation failed");
            $finish;
        end
        if (rst_n && out_valid && !out_stall)
            board.check_solution(sol1, sol2, sol3, status, overflow);
    end

    always @(negedge clk)
        out_stall <= !calm && ($urandom_range(99) < 22);

    // in_valid stays high between back-to-back items; idle cycles and drain drop it
    task automatic send_system(sys_t s);
        while (!calm && $urandom_range(99) < 22)
        begin
            in_valid <= 0;
            @(negedge clk);
        end
        sys_in <= s;
        in_valid <= 1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        board.note_system(s);
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid <= 0;
        while (board.pending.size() != 0)
            @(negedge clk);
        repeat (45) @(negedge clk);
    endtask

    task automatic set_threshold(logic [THR_W-1:0] v);
        drain();
        cfg_wdata <= v;
        cfg_we <= 1;
        @(negedge clk);
        cfg_we <= 0;
        board.thr = v;
    endtask

    function automatic logic [15:0] pick_entry(int mode);
        case (mode)
            0: return 16'($urandom);
            1: return 16'($signed($urandom_range(1024)) - 512);
            default: return 16'($urandom_range(3) == 0 ? 0 : $urandom_range(1) ? 16'h7FFF : 16'h8000);
        endcase
    endfunction

    function automatic sys_t rand_system();
        sys_t s;
        int mode;
        mode = $urandom_range(9) < 5 ? 0 : ($urandom_range(3) == 0 ? 2 : 1);
        s = {pick_entry(mode), pick_entry(mode), pick_entry(mode), pick_entry(mode),
             pick_entry(mode), pick_entry(mode), pick_entry(mode), pick_entry(mode),
             pick_entry(mode), pick_entry(0), pick_entry(0), pick_entry(0)};
        // dependent rows give singular systems
        if ($urandom_range(9) == 0)
        begin
            s.m31 = s.m11; s.m32 = s.m12; s.m33 = s.m13;
        end
        return s;
    endfunction

    initial
    begin
        sys_t s;
        repeat (11) @(negedge clk);
        rst_n = 1;
        @(negedge clk);
        // identity, scaled identity, extremes, singular, tiny det
        s = '0; s.m11 = 16'h0100; s.m22 = 16'h0100; s.m33 = 16'h0100;
        s.rhs1 = 16'h7FFF; s.rhs2 = 16'h8000; s.rhs3 = 16'h0001;
        send_system(s);
        s.m11 = 16'h0001; s.m22 = 16'h0001; s.m33 = 16'h0001;
        send_system(s);
        s.m11 = 16'h8000; s.m22 = 16'h8000; s.m33 = 16'h8000;
        send_system(s);
        s = '0;
        send_system(s);
        s = {12{16'h7FFF}};
        send_system(s);
        s = {12{16'h8000}};
        send_system(s);
        s = {16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000,
             16'h8000, 16'h8000, 16'h7FFF, 16'hFFFF, 16'h8000, 16'h7FFF};
        send_system(s);
        s = {16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 16'h0000,
             16'h0000, 16'h0000, 16'h0001, 16'h8000, 16'h7FFF, 16'hFFFF};
        send_system(s);
        set_threshold('1);
        for (int i = 0; i < 6; i++)
            send_system(rand_system());
        set_threshold(0);
        send_system(s);
        for (int i = 0; i < 6; i++)
            send_system(rand_system());
        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0: set_threshold(1);
                1: set_threshold(49'h1_0000_0000_0000);
                2: set_threshold(49'($urandom_range(1 << 20)));
                3: set_threshold({17'($urandom), 32'($urandom)});
                4: set_threshold(49'h0_0000_0100_0000);
                default: set_threshold(49'({$urandom, $urandom}));
            endcase
            calm = (ph == 2);
            for (int i = 0; i < 300; i++)
            begin
                if (i == 150)
                    drain();
                send_system(rand_system());
            end
            calm = 0;
        end
        drain();
        if (board.errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
`default_nettype wire
